@@ sv/eth_ipv4_l4_header_parser_macros.svh @@
// assertion macros for the header parser checker
`ifndef ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH
`define EHP_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
`define EHP_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

@@ sv/ehp_pkg.sv @@
// ----------------------------------------------------------------------------
// ehp_pkg
// types and constants shared by the header parser modules
// ----------------------------------------------------------------------------
package ehp_pkg;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_NOT_IPV4  = 2'd2;
	localparam logic [1:0] ST_BAD_IPV4  = 2'd3;

	localparam logic [1:0] HINT_NONE    = 2'd0;
	localparam logic [1:0] HINT_HTTPS   = 2'd1;
	localparam logic [1:0] HINT_HTTP    = 2'd2;
	localparam logic [1:0] HINT_DNS     = 2'd3;

	localparam logic [1:0] REG_HTTPS    = 2'd0;
	localparam logic [1:0] REG_HTTP     = 2'd1;
	localparam logic [1:0] REG_HTTP_ALT = 2'd2;
	localparam logic [1:0] REG_DNS      = 2'd3;

	localparam logic [15:0] ETHERTYPE_IP = 16'h0800;
	localparam logic [7:0]  IP_L4_TCP    = 8'd6;
	localparam logic [7:0]  IP_L4_UDP    = 8'd17;

	typedef struct packed {
		logic [15:0] eth_type;
		logic [3:0]  ip_ver;
		logic [3:0]  ihl;
		logic [15:0] tot_len;
		logic [7:0]  proto;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [3:0]  thw;
		logic [7:0]  flags;
	} frame_t;

	typedef struct packed {
		logic [15:0] https;
		logic [15:0] http;
		logic [15:0] http_alt;
		logic [15:0] dns;
	} ports_t;
endpackage

@@ sv/ehp_front.sv @@
// ----------------------------------------------------------------------------
// ehp_front
// byte capture of the frame headers, hands a snapshot per frame downstream
// ----------------------------------------------------------------------------
module ehp_front #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_take,
	input  logic [7:0]                   frame_byte,
	input  logic                         frame_last,
	output logic                         snap_push,
	output ehp_pkg::frame_t              snap_frame,
	output logic [LENGTH_BITS-1:0]       snap_len
);
	logic [LENGTH_BITS-1:0] cnt_q;
	ehp_pkg::frame_t        fr_q;
	ehp_pkg::frame_t        fr_nx;
	logic [LENGTH_BITS:0]   base;
	logic [LENGTH_BITS:0]   rel;
	logic [LENGTH_BITS:0]   pos;
	logic                   in_l4;

	assign pos  = {1'b0, cnt_q};
	assign base = (LENGTH_BITS+1)'(14) + (LENGTH_BITS+1)'({fr_q.ihl, 2'b00});
	assign rel  = pos - base;
	assign in_l4 = (fr_q.ihl >= 4'd5) && (pos >= (LENGTH_BITS+1)'(34)) &&
		(pos >= base) && (rel < (LENGTH_BITS+1)'(14));

	always_comb begin
		fr_nx = fr_q;
		if (pos == (LENGTH_BITS+1)'(12) || pos == (LENGTH_BITS+1)'(13)) begin
			fr_nx.eth_type = {fr_q.eth_type[7:0], frame_byte};
		end else if (pos == (LENGTH_BITS+1)'(14)) begin
			fr_nx.ip_ver = frame_byte[7:4];
			fr_nx.ihl    = frame_byte[3:0];
		end else if (pos == (LENGTH_BITS+1)'(16) || pos == (LENGTH_BITS+1)'(17)) begin
			fr_nx.tot_len = {fr_q.tot_len[7:0], frame_byte};
		end else if (pos == (LENGTH_BITS+1)'(23)) begin
			fr_nx.proto = frame_byte;
		end else if (pos >= (LENGTH_BITS+1)'(26) && pos <= (LENGTH_BITS+1)'(29)) begin
			fr_nx.sip = {fr_q.sip[23:0], frame_byte};
		end else if (pos >= (LENGTH_BITS+1)'(30) && pos <= (LENGTH_BITS+1)'(33)) begin
			fr_nx.dip = {fr_q.dip[23:0], frame_byte};
		end
		if (in_l4) begin
			if (rel < (LENGTH_BITS+1)'(2)) begin
				fr_nx.sport = {fr_q.sport[7:0], frame_byte};
			end else if (rel < (LENGTH_BITS+1)'(4)) begin
				fr_nx.dport = {fr_q.dport[7:0], frame_byte};
			end else if (rel < (LENGTH_BITS+1)'(8)) begin
				fr_nx.seq = {fr_q.seq[23:0], frame_byte};
			end else if (rel < (LENGTH_BITS+1)'(12)) begin
				fr_nx.ack = {fr_q.ack[23:0], frame_byte};
			end else if (rel == (LENGTH_BITS+1)'(12)) begin
				fr_nx.thw = frame_byte[7:4];
			end else begin
				fr_nx.flags = frame_byte;
			end
		end
	end

	assign snap_push  = in_take && frame_last;
	assign snap_frame = fr_nx;
	assign snap_len   = (&cnt_q) ? cnt_q : cnt_q + LENGTH_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fr_q  <= '0;
		end else if (in_take) begin
			if (frame_last) begin
				cnt_q <= '0;
				fr_q  <= '0;
			end else begin
				cnt_q <= snap_len;
				fr_q  <= fr_nx;
			end
		end
	end
endmodule

@@ sv/ehp_fifo.sv @@
// ----------------------------------------------------------------------------
// ehp_fifo
// small queue of frame snapshots between capture and result stages
// ----------------------------------------------------------------------------
module ehp_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty,
	output logic             is_full
);
	logic [WIDTH-1:0] mem [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign not_empty = cnt_q != 2'd0;
	assign is_full   = cnt_q == 2'd2;
	assign rd_data   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

@@ sv/ehp_back.sv @@
// ----------------------------------------------------------------------------
// ehp_back
// turns a frame snapshot into the result and holds it until popped
// ----------------------------------------------------------------------------
module ehp_back #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   snap_valid,
	input  ehp_pkg::frame_t        snap_frame,
	input  logic [LENGTH_BITS-1:0] snap_len,
	output logic                   snap_take,
	input  ehp_pkg::ports_t        ports,
	input  logic                   pop,
	output logic                   empty,
	output logic [1:0]             status,
	output logic [7:0]             protocol,
	output logic [31:0]            src_ip,
	output logic [31:0]            dst_ip,
	output logic [15:0]            l4_sport,
	output logic [15:0]            l4_dport,
	output logic [7:0]             ctl_flags,
	output logic [31:0]            seq_num,
	output logic [31:0]            ack_num,
	output logic [15:0]            data_start,
	output logic [15:0]            data_bytes,
	output logic [1:0]             service
);
	localparam int WL = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

	logic          ovalid_q;
	logic [WL-1:0] len, avail, hdr, tot, l4a, l4, room, th0, th1, th;
	logic [1:0]    st;
	logic          is_tcp, is_udp;
	logic [15:0]   sp, dp, off, plen;
	logic [1:0]    hint;

	assign empty     = !ovalid_q;
	assign snap_take = snap_valid && (!ovalid_q || pop);

	assign len   = WL'(snap_len);
	assign avail = len - WL'(14);
	assign hdr   = WL'({snap_frame.ihl, 2'b00});
	assign tot   = WL'(snap_frame.tot_len);
	assign room  = avail - hdr;
	assign l4a   = (tot > hdr) ? tot - hdr : '0;
	assign l4    = (l4a > room) ? room : l4a;
	assign th0   = WL'({snap_frame.thw, 2'b00});
	assign th1   = (th0 < WL'(20)) ? WL'(20) : th0;
	assign th    = (th1 > l4) ? l4 : th1;

	always_comb begin
		if (len < WL'(14)) begin
			st = ehp_pkg::ST_SHORT;
		end else if (snap_frame.eth_type != ehp_pkg::ETHERTYPE_IP) begin
			st = ehp_pkg::ST_NOT_IPV4;
		end else if (avail < WL'(20) || snap_frame.ip_ver != 4'd4 || hdr < WL'(20) ||
			hdr > avail) begin
			st = ehp_pkg::ST_BAD_IPV4;
		end else begin
			st = ehp_pkg::ST_OK;
		end
		is_tcp = (snap_frame.proto == ehp_pkg::IP_L4_TCP) && (l4 >= WL'(20));
		is_udp = (snap_frame.proto == ehp_pkg::IP_L4_UDP) && (l4 >= WL'(8));
		sp   = '0;
		dp   = '0;
		off  = '0;
		plen = '0;
		if (is_tcp) begin
			sp = snap_frame.sport;
			dp = snap_frame.dport;
			if (th < l4) begin
				off  = 16'(WL'(14) + hdr + th);
				plen = 16'(l4 - th);
			end
		end else if (is_udp) begin
			sp = snap_frame.sport;
			dp = snap_frame.dport;
			if (l4 > WL'(8)) begin
				off  = 16'(WL'(22) + hdr);
				plen = 16'(l4 - WL'(8));
			end
		end
		if (sp == ports.https || dp == ports.https) begin
			hint = ehp_pkg::HINT_HTTPS;
		end else if (sp == ports.http || dp == ports.http || sp == ports.http_alt ||
			dp == ports.http_alt) begin
			hint = ehp_pkg::HINT_HTTP;
		end else if (sp == ports.dns || dp == ports.dns) begin
			hint = ehp_pkg::HINT_DNS;
		end else begin
			hint = ehp_pkg::HINT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (snap_take) begin
			ovalid_q <= 1'b1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take) begin
			status     <= st;
			protocol   <= '0;
			src_ip     <= '0;
			dst_ip     <= '0;
			l4_sport   <= '0;
			l4_dport   <= '0;
			ctl_flags  <= '0;
			seq_num    <= '0;
			ack_num    <= '0;
			data_start <= '0;
			data_bytes <= '0;
			service    <= ehp_pkg::HINT_NONE;
			if (st == ehp_pkg::ST_OK) begin
				protocol   <= snap_frame.proto;
				src_ip     <= snap_frame.sip;
				dst_ip     <= snap_frame.dip;
				l4_sport   <= sp;
				l4_dport   <= dp;
				data_start <= off;
				data_bytes <= plen;
				service    <= hint;
				if (is_tcp) begin
					ctl_flags <= snap_frame.flags;
					seq_num   <= snap_frame.seq;
					ack_num   <= snap_frame.ack;
				end
			end
		end
	end
endmodule

@@ sv/eth_ipv4_l4_header_parser.sv @@
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser
// Ethernet II / IPv4 / TCP / UDP header parser with port based app hint
// ----------------------------------------------------------------------------
// input: push a frame byte with frame_last on the final byte; a byte is taken
// when push is high and full is low, one byte per cycle.
// results: one per frame, shown while empty is low, taken on pop.
// result path: the snapshot is queued, then loaded into the result register.
// throughput: one byte per cycle while full is low, set by the capture stage; a two entry
// snapshot queue sits between capture and the result register.
// if pop stays low, the result holds; capture goes on until the queue fills,
// then full rises.
// config: cfg_valid/cfg_index/cfg_data, always ready; write only when idle.
// reset: frame state cleared, queue and result emptied, port registers loaded
// with 443, 80, 8080 and 53.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser #(
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  protocol,
	output logic [31:0] src_ip,
	output logic [31:0] dst_ip,
	output logic [15:0] l4_sport,
	output logic [15:0] l4_dport,
	output logic [7:0]  ctl_flags,
	output logic [31:0] seq_num,
	output logic [31:0] ack_num,
	output logic [15:0] data_start,
	output logic [15:0] data_bytes,
	output logic [1:0]  service,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int SW = $bits(ehp_pkg::frame_t) + LENGTH_BITS;

	ehp_pkg::ports_t        ports_q;
	logic                   in_take;
	logic                   snap_push;
	ehp_pkg::frame_t        f_frame, b_frame;
	logic [LENGTH_BITS-1:0] f_len, b_len;
	logic [SW-1:0]          q_out;
	logic                   q_ne, q_full, q_take;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign in_take   = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_q.https    <= 16'd443;
			ports_q.http     <= 16'd80;
			ports_q.http_alt <= 16'd8080;
			ports_q.dns      <= 16'd53;
		end else if (cfg_valid) begin
			case (cfg_index)
				ehp_pkg::REG_HTTPS:    ports_q.https    <= cfg_data;
				ehp_pkg::REG_HTTP:     ports_q.http     <= cfg_data;
				ehp_pkg::REG_HTTP_ALT: ports_q.http_alt <= cfg_data;
				ehp_pkg::REG_DNS:      ports_q.dns      <= cfg_data;
				default: ;
			endcase
		end
	end

	ehp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_take(in_take),
		.frame_byte(frame_byte), .frame_last(frame_last),
		.snap_push(snap_push), .snap_frame(f_frame), .snap_len(f_len)
	);

	ehp_fifo #(.WIDTH(SW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(snap_push), .wr_data({f_frame, f_len}),
		.rd_en(q_take), .rd_data(q_out), .not_empty(q_ne), .is_full(q_full)
	);

	assign b_frame = q_out[SW-1:LENGTH_BITS];
	assign b_len   = q_out[LENGTH_BITS-1:0];

	ehp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .snap_valid(q_ne), .snap_frame(b_frame),
		.snap_len(b_len), .snap_take(q_take), .ports(ports_q), .pop(pop),
		.empty(empty), .status(status), .protocol(protocol), .src_ip(src_ip),
		.dst_ip(dst_ip), .l4_sport(l4_sport), .l4_dport(l4_dport),
		.ctl_flags(ctl_flags), .seq_num(seq_num), .ack_num(ack_num),
		.data_start(data_start), .data_bytes(data_bytes),
		.service(service)
	);
endmodule

@@ sv/ehp_checker.sv @@
// ----------------------------------------------------------------------------
// ehp_checker
// port level checks of the header parser, bound to the top level
// ----------------------------------------------------------------------------
`include "eth_ipv4_l4_header_parser_macros.svh"
module ehp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [7:0]  protocol,
	input logic [31:0] src_ip,
	input logic [15:0] l4_sport,
	input logic [31:0] seq_num,
	input logic [15:0] data_start,
	input logic [15:0] data_bytes,
	input logic [1:0]  service
);
	logic         res_fail;
	logic         res_stall;
	logic         res_data;
	logic [123:0] res_key;
	logic [87:0]  fail_head;
	logic [17:0]  fail_tail;

	assign res_fail  = !empty && (status != ehp_pkg::ST_OK);
	assign res_stall = !empty && !pop;
	assign res_data  = !empty && (data_bytes != 16'd0);
	assign res_key   = {status, protocol, src_ip, l4_sport, seq_num, data_start, data_bytes,
		service};
	assign fail_head = {protocol, src_ip, l4_sport, seq_num};
	assign fail_tail = {service, data_bytes};

	`EHP_ASSERT_NEXT(a_hold, res_stall, !empty && $stable(res_key), "result moved while held")
	`EHP_ASSERT_NOW(a_fail_zero, res_fail, fail_head == '0, "failing result not zeroed")
	`EHP_ASSERT_NOW(a_fail_hint, res_fail, fail_tail == '0, "failing result has hint or data")
	`EHP_ASSERT_NOW(a_payload, res_data, data_start != 16'd0, "payload without offset")
endmodule

bind eth_ipv4_l4_header_parser ehp_checker u_ehp_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .status(status),
	.protocol(protocol), .src_ip(src_ip), .l4_sport(l4_sport), .seq_num(seq_num),
	.data_start(data_start), .data_bytes(data_bytes), .service(service)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// header parser testbench
// feeds Ethernet frames byte by byte through the queue style ports, predicts
// each parse result from its own copy of the frame state and port registers
// (typed frames take their listed status), and checks each popped result field
// by field under changing flow control
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  status;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] l4_sport;
		logic [15:0] l4_dport;
		logic [7:0]  ctl_flags;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [15:0] data_start;
		logic [15:0] data_bytes;
		logic [1:0]  service;
	} parse_result_t;

	typedef struct {
		int          len;
		logic [15:0] etype;
		logic [7:0]  ver_ihl;
		logic [15:0] tot_len;
		logic [7:0]  proto;
		logic [7:0]  doff;
		bit          typed;
		logic [1:0]  typed_status;
	} frame_desc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] frame_byte = 8'd0;
	logic frame_last = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] status;
	logic [7:0] protocol;
	logic [31:0] src_ip, dst_ip, seq_num, ack_num;
	logic [15:0] l4_sport, l4_dport, data_start, data_bytes;
	logic [7:0] ctl_flags;
	logic [1:0] service;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = ehp_pkg::REG_HTTPS;
	logic [15:0] cfg_data = 16'd0;

	eth_ipv4_l4_header_parser DUT (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// port registers and frame state as the parser should hold them
	logic [15:0] port_regs [4];
	int unsigned n_bytes;
	logic [15:0] ety;
	logic [3:0] ver, ihl, thw;
	logic [15:0] tlen, sport, dport;
	logic [7:0] proto, flags;
	logic [31:0] sip, dip, seq, ack;

	parse_result_t parse_results_due [$];
	bit typed_pending;
	logic [1:0] typed_status;
	int errors = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	bit hold_req = 1'b0;
	bit rx_hold = 1'b0;
	longint cycles = 0;
	logic [7:0] frame_bytes [$];

	function automatic void clear_frame_state();
		n_bytes = 0; ety = 0; ver = 0; ihl = 0; tlen = 0; proto = 0;
		sip = 0; dip = 0; sport = 0; dport = 0; seq = 0; ack = 0; thw = 0; flags = 0;
	endfunction

	function automatic parse_result_t parse_outcome();
		parse_result_t r;
		int avail, hdr, l4, th, sp, dp, off, plen;
		r = '{default: '0};
		sp = 0; dp = 0; off = 0; plen = 0;
		if (n_bytes < 14) begin
			r.status = ehp_pkg::ST_SHORT;
			return r;
		end
		if (ety != ehp_pkg::ETHERTYPE_IP) begin
			r.status = ehp_pkg::ST_NOT_IPV4;
			return r;
		end
		avail = n_bytes - 14;
		hdr = 4 * ihl;
		if (avail < 20 || ver != 4'd4 || hdr < 20 || hdr > avail) begin
			r.status = ehp_pkg::ST_BAD_IPV4;
			return r;
		end
		l4 = (tlen > hdr) ? tlen - hdr : 0;
		if (l4 > avail - hdr)
			l4 = avail - hdr;
		r.status = ehp_pkg::ST_OK;
		r.protocol = proto;
		r.src_ip = sip;
		r.dst_ip = dip;
		if (l4 > 0 && proto == ehp_pkg::IP_L4_TCP && l4 >= 20) begin
			sp = sport; dp = dport;
			r.ctl_flags = flags;
			r.seq_num = seq;
			r.ack_num = ack;
			th = 4 * thw;
			if (th < 20) th = 20;
			if (th > l4) th = l4;
			if (th < l4) begin
				off = 14 + hdr + th;
				plen = l4 - th;
			end
		end else if (l4 > 0 && proto == ehp_pkg::IP_L4_UDP && l4 >= 8) begin
			sp = sport; dp = dport;
			if (l4 > 8) begin
				off = 14 + hdr + 8;
				plen = l4 - 8;
			end
		end
		r.l4_sport = 16'(sp);
		r.l4_dport = 16'(dp);
		r.data_start = 16'(off);
		r.data_bytes = 16'(plen);
		if (sp == port_regs[ehp_pkg::REG_HTTPS] || dp == port_regs[ehp_pkg::REG_HTTPS])
			r.service = ehp_pkg::HINT_HTTPS;
		else if (sp == port_regs[ehp_pkg::REG_HTTP] || dp == port_regs[ehp_pkg::REG_HTTP] ||
				sp == port_regs[ehp_pkg::REG_HTTP_ALT] ||
				dp == port_regs[ehp_pkg::REG_HTTP_ALT])
			r.service = ehp_pkg::HINT_HTTP;
		else if (sp == port_regs[ehp_pkg::REG_DNS] || dp == port_regs[ehp_pkg::REG_DNS])
			r.service = ehp_pkg::HINT_DNS;
		else
			r.service = ehp_pkg::HINT_NONE;
		return r;
	endfunction

	function automatic void take_byte(logic [7:0] b, logic last);
		int p, base, r;
		parse_result_t typed_res;
		p = n_bytes;
		if (p == 12 || p == 13)
			ety = {ety[7:0], b};
		else if (p == 14) begin
			ver = b[7:4];
			ihl = b[3:0];
		end else if (p == 16 || p == 17)
			tlen = {tlen[7:0], b};
		else if (p == 23)
			proto = b;
		else if (p >= 26 && p <= 29)
			sip = {sip[23:0], b};
		else if (p >= 30 && p <= 33)
			dip = {dip[23:0], b};
		if (ihl >= 5 && p >= 34) begin
			base = 14 + 4 * ihl;
			if (p >= base && p < base + 14) begin
				r = p - base;
				if (r < 2) sport = {sport[7:0], b};
				else if (r < 4) dport = {dport[7:0], b};
				else if (r < 8) seq = {seq[23:0], b};
				else if (r < 12) ack = {ack[23:0], b};
				else if (r == 12) thw = b[7:4];
				else flags = b;
			end
		end
		if (n_bytes < 65535)
			n_bytes++;
		if (last) begin
			if (typed_pending) begin
				// failing frames: status as listed, every other field zero
				typed_res = '{default: '0};
				typed_res.status = typed_status;
				parse_results_due.push_back(typed_res);
				typed_pending = 0;
			end else
				parse_results_due.push_back(parse_outcome());
			clear_frame_state();
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// result side
	always @(posedge clk) begin
		parse_result_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (parse_results_due.size() == 0) begin
					$display("%0t: status expected no result actual %0d", $realtime, status);
					errors++;
				end else begin
					e = parse_results_due.pop_front();
					check_field("status", e.status, status);
					check_field("protocol", e.protocol, protocol);
					check_field("src_ip", e.src_ip, src_ip);
					check_field("dst_ip", e.dst_ip, dst_ip);
					check_field("l4_sport", e.l4_sport, l4_sport);
					check_field("l4_dport", e.l4_dport, l4_dport);
					check_field("ctl_flags", e.ctl_flags, ctl_flags);
					check_field("seq_num", e.seq_num, seq_num);
					check_field("ack_num", e.ack_num, ack_num);
					check_field("data_start", e.data_start, data_start);
					check_field("data_bytes", e.data_bytes, data_bytes);
					check_field("service", e.service, service);
				end
			end
			if (rx_hold)
				pop <= 1'b0;
			else
				pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	// long receiver stall, counted here
	always begin
		@(posedge hold_req);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		push <= 1'b1;
		frame_byte <= b;
		frame_last <= last;
		do @(posedge clk); while (full);
		take_byte(b, last);
		if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_frame(frame_desc_t d);
		int base;
		frame_bytes.delete();
		for (int i = 0; i < d.len; i++)
			frame_bytes.push_back(8'($urandom_range(255)));
		base = 14 + 4 * d.ver_ihl[3:0];
		if (d.len > 12) frame_bytes[12] = d.etype[15:8];
		if (d.len > 13) frame_bytes[13] = d.etype[7:0];
		if (d.len > 14) frame_bytes[14] = d.ver_ihl;
		if (d.len > 16) frame_bytes[16] = d.tot_len[15:8];
		if (d.len > 17) frame_bytes[17] = d.tot_len[7:0];
		if (d.len > 23) frame_bytes[23] = d.proto;
		if (d.len > base + 1 && $urandom_range(1)) begin
			frame_bytes[base] = 8'h01;
			frame_bytes[base + 1] = 8'hBB;
		end
		if (d.len > base + 3 && $urandom_range(2) == 0) begin
			frame_bytes[base + 2] = 8'h00;
			frame_bytes[base + 3] = $urandom_range(1) ? 8'd80 : 8'd53;
		end
		if (d.len > base + 12) frame_bytes[base + 12] = d.doff;
		typed_pending = d.typed;
		typed_status = d.typed_status;
		for (int i = 0; i < d.len; i++)
			send_byte(frame_bytes[i], i == d.len - 1);
		frames_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (parse_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_port_reg(logic [1:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		port_regs[idx] = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic frame_desc_t random_frame();
		frame_desc_t d;
		int l4;
		d.typed = 0;
		d.typed_status = ehp_pkg::ST_OK;
		d.etype = ($urandom_range(9) == 0) ? 16'($urandom) : ehp_pkg::ETHERTYPE_IP;
		d.ver_ihl = ($urandom_range(9) < 7) ? 8'h45 :
			(($urandom_range(3) == 0) ? 8'($urandom) : {4'h4, 4'($urandom_range(15))});
		case ($urandom_range(3))
			0: d.proto = ehp_pkg::IP_L4_UDP;
			1: d.proto = 8'($urandom);
			default: d.proto = ehp_pkg::IP_L4_TCP;
		endcase
		d.doff = ($urandom_range(2) == 0) ? 8'($urandom) : 8'h50;
		l4 = $urandom_range(30);
		d.tot_len = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(4 * d.ver_ihl[3:0] + l4);
		d.len = 14 + 4 * d.ver_ihl[3:0] + l4 + $urandom_range(4);
		if ($urandom_range(7) == 0)
			d.len = $urandom_range(1, d.len);
		return d;
	endfunction

	// length, ethertype, version/ihl, total length, protocol, data offset, typed, status
	frame_desc_t directed_frames [] = '{
		'{1,  16'h0800, 8'h45, 16'd40,   ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_SHORT},
		'{13, 16'h0800, 8'h45, 16'd40,   ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_SHORT},
		'{14, 16'h0800, 8'h45, 16'd40,   ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_BAD_IPV4},
		'{14, 16'h86DD, 8'h45, 16'd40,   ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_NOT_IPV4},
		'{34, 16'h0800, 8'h55, 16'd20,   ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_BAD_IPV4},
		'{33, 16'h0800, 8'h45, 16'd20,   ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_BAD_IPV4},
		'{34, 16'h0800, 8'h45, 16'd20,   ehp_pkg::IP_L4_TCP, 8'h50, 0, ehp_pkg::ST_OK},
		'{56, 16'h0800, 8'h45, 16'd42,   ehp_pkg::IP_L4_TCP, 8'h00, 0, ehp_pkg::ST_OK},
		'{42, 16'h0800, 8'h45, 16'd28,   ehp_pkg::IP_L4_UDP, 8'h00, 0, ehp_pkg::ST_OK},
		'{45, 16'h0800, 8'h45, 16'hFFFF, ehp_pkg::IP_L4_UDP, 8'h00, 0, ehp_pkg::ST_OK}
	};

	initial begin
		port_regs[ehp_pkg::REG_HTTPS] = 16'd443;
		port_regs[ehp_pkg::REG_HTTP] = 16'd80;
		port_regs[ehp_pkg::REG_HTTP_ALT] = 16'd8080;
		port_regs[ehp_pkg::REG_DNS] = 16'd53;
		clear_frame_state();
		typed_pending = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (directed_frames[i])
			send_frame(directed_frames[i]);
		wait_drained();

		// phase settings: two random ports, extremes, then ports that unparsed frames hit
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 0) begin
				write_port_reg(ehp_pkg::REG_HTTPS, 16'($urandom));
				write_port_reg(ehp_pkg::REG_HTTP, 16'd80);
				write_port_reg(ehp_pkg::REG_HTTP_ALT, 16'($urandom));
				write_port_reg(ehp_pkg::REG_DNS, 16'd53);
				tx_idle = 13; rx_idle = 76;
			end else if (phase == 1) begin
				write_port_reg(ehp_pkg::REG_HTTPS, 16'hFFFF);
				write_port_reg(ehp_pkg::REG_HTTP, 16'h0000);
				write_port_reg(ehp_pkg::REG_HTTP_ALT, 16'hFFFF);
				write_port_reg(ehp_pkg::REG_DNS, 16'h0000);
				tx_idle = 76; rx_idle = 13;
			end else begin
				write_port_reg(ehp_pkg::REG_HTTPS, 16'd443);
				write_port_reg(ehp_pkg::REG_HTTP, 16'd8080);
				write_port_reg(ehp_pkg::REG_HTTP_ALT, 16'd80);
				write_port_reg(ehp_pkg::REG_DNS, 16'd53);
				tx_idle = 0; rx_idle = 0;
			end
			send_frame(random_frame());
			// stall the result side while short frames keep coming
			hold_req = 1'b1;
			for (int n = 0; n < 6; n++)
				send_frame('{$urandom_range(1, 6), ehp_pkg::ETHERTYPE_IP, 8'h45, 16'd40,
					ehp_pkg::IP_L4_TCP, 8'h50, 1, ehp_pkg::ST_SHORT});
			wait_drained();
			hold_req = 1'b0;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d frames parsed across three port settings and three flow control mixes",
			frames_sent);
		$display("%0d results checked, including short, non-IPv4 and bad header frames",
			results_seen);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/ehp_pkg.sv
sv/ehp_front.sv
sv/ehp_fifo.sv
sv/ehp_back.sv
sv/eth_ipv4_l4_header_parser.sv
sv/ehp_checker.sv
tb/testbench.sv
